[src/fixed_point_alu_q24_8_macros.svh]
// Assertion macros used by the ALU RTL (fpa_fifo).
// Depends on a clk and an arst_n being in scope where used.
`ifndef FIXED_POINT_ALU_Q24_8_MACROS_SVH
`define FIXED_POINT_ALU_Q24_8_MACROS_SVH

// Concurrent check, clocked on clk, disabled while in reset.
`define FPA_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define FPA_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/fpa_pkg.sv]
// Types and constants for the Q24.8 fixed-point ALU.
// No dependencies.
package fpa_pkg;

	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_DIV = 4'd3;
	localparam logic [3:0] OP_MIN = 4'd4;
	localparam logic [3:0] OP_MAX = 4'd5;
	localparam logic [3:0] OP_FROM_INT = 4'd6;
	localparam logic [3:0] OP_TO_INT = 4'd7;
	localparam logic [3:0] OP_INC = 4'd8;
	localparam logic [3:0] OP_DEC = 4'd9;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	typedef struct packed {
		logic [3:0]         func;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} in_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic               a_less;
		logic               a_equal;
		logic               a_greater;
		logic               div_by_zero;
		logic               overflow;
	} out_t;

	// Classified beat handed from front to back.
	typedef struct packed {
		logic [3:0]         func;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic               lt;
		logic               eq;
		logic               gt;
		logic               b_zero;
		logic               q_neg;
		logic [31:0]        mag_a;
		logic [31:0]        mag_b;
	} cls_t;

endpackage

[src/fpa_fifo.sv]
// Small register FIFO used between front and back and at the result side.
// Depends on fixed_point_alu_q24_8_macros.svh.
`include "fixed_point_alu_q24_8_macros.svh"

module fpa_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [PW:0]      cnt_q;

	assign full    = (cnt_q == (PW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`FPA_CHECK(a_no_wr_full, !(wr && full && !rd), "fifo written while full")
	`FPA_CHECK(a_no_rd_empty, !(rd && empty), "fifo read while empty")
	`FPA_CHECK_NEXT(a_wr_fills, wr && !rd, !empty, "fifo empty after a lone write")

endmodule

[src/fpa_front.sv]
// Front end: takes input beats, compares operands, takes magnitudes for divide.
// Depends on fpa_pkg.
module fpa_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  fpa_pkg::in_t req,
	output logic         full,
	input  logic         q_full,
	output logic         q_wr,
	output fpa_pkg::cls_t q_data
);
	fpa_pkg::cls_t cls;
	fpa_pkg::cls_t item_s1;
	logic          vld_s1;
	logic          take;

	always_comb begin
		cls.func   = req.func;
		cls.a      = req.operand_a;
		cls.b      = req.operand_b;
		cls.lt     = req.operand_a < req.operand_b;
		cls.eq     = req.operand_a == req.operand_b;
		cls.gt     = req.operand_a > req.operand_b;
		cls.b_zero = req.operand_b == '0;
		cls.q_neg  = req.operand_a[31] ^ req.operand_b[31];
		cls.mag_a  = req.operand_a[31] ? 32'(-req.operand_a) : 32'(req.operand_a);
		cls.mag_b  = req.operand_b[31] ? 32'(-req.operand_b) : 32'(req.operand_b);
	end

	assign q_wr   = vld_s1 && !q_full;
	assign q_data = item_s1;
	assign full   = vld_s1 && q_full;
	assign take   = push && !full;

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (q_wr) begin
			vld_s1 <= 1'b0;
		end
	end

endmodule

[src/fpa_back.sv]
// Back end: multiply, simple ops, and a one-bit-per-stage restoring divider.
// Depends on fpa_pkg.
module fpa_back #(
	parameter int FRAC_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  fpa_pkg::cls_t q_data,
	output logic          q_rd,
	input  logic          o_full,
	output logic          o_wr,
	output fpa_pkg::out_t o_data
);
	localparam int W = 32 + FRAC_BITS;

	typedef struct packed {
		logic        valid;
		logic [3:0]  func;
		logic [31:0] res;
		logic        lt;
		logic        eq;
		logic        gt;
		logic        b_zero;
		logic        q_neg;
		logic [31:0] dvs;
		logic [31:0] rem;
		logic [W-1:0] quo;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} stg_t;

	stg_t stg_s [W+1];
	logic adv;

	assign adv  = !(stg_s[W].valid && o_full);
	assign q_rd = adv && !q_empty;

	// entry 0 loads from the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_s[0] <= '0;
		end else if (adv) begin
			stg_s[0].valid  <= !q_empty;
			stg_s[0].func   <= q_data.func;
			stg_s[0].res    <= '0;
			stg_s[0].lt     <= q_data.lt;
			stg_s[0].eq     <= q_data.eq;
			stg_s[0].gt     <= q_data.gt;
			stg_s[0].b_zero <= q_data.b_zero;
			stg_s[0].q_neg  <= q_data.q_neg;
			stg_s[0].dvs    <= q_data.mag_b;
			stg_s[0].rem    <= '0;
			stg_s[0].quo    <= {q_data.mag_a, {FRAC_BITS{1'b0}}};
			stg_s[0].a      <= q_data.a;
			stg_s[0].b      <= q_data.b;
		end
	end

	// all non-divide results formed on the way into entry 1
	logic signed [63:0] prod;
	logic [31:0]        simple;
	assign prod = 64'(stg_s[0].a) * 64'(stg_s[0].b);

	always_comb begin
		unique case (stg_s[0].func)
			fpa_pkg::OP_ADD:      simple = 32'(stg_s[0].a + stg_s[0].b);
			fpa_pkg::OP_SUB:      simple = 32'(stg_s[0].a - stg_s[0].b);
			fpa_pkg::OP_MUL:      simple = prod[FRAC_BITS+31:FRAC_BITS];
			fpa_pkg::OP_MIN:      simple = stg_s[0].lt ? stg_s[0].a : stg_s[0].b;
			fpa_pkg::OP_MAX:      simple = stg_s[0].gt ? stg_s[0].a : stg_s[0].b;
			fpa_pkg::OP_FROM_INT: simple = 32'(stg_s[0].a <<< FRAC_BITS);
			fpa_pkg::OP_TO_INT:   simple = 32'(stg_s[0].a >>> FRAC_BITS);
			fpa_pkg::OP_INC:      simple = 32'(stg_s[0].a + 32'sd1);
			fpa_pkg::OP_DEC:      simple = 32'(stg_s[0].a - 32'sd1);
			default:              simple = '0;
		endcase
	end

	for (genvar k = 0; k < W; k++) begin : g_step
		logic [32:0] sh;
		logic        ge;
		stg_t        nxt;
		always_comb begin
			sh  = {stg_s[k].rem, stg_s[k].quo[W-1]};
			ge  = sh >= {1'b0, stg_s[k].dvs};
			nxt = stg_s[k];
			nxt.rem = ge ? 32'(sh - {1'b0, stg_s[k].dvs}) : sh[31:0];
			nxt.quo = {stg_s[k].quo[W-2:0], ge};
			if (k == 0) begin
				nxt.res = simple;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg_s[k+1] <= '0;
			end else if (adv) begin
				stg_s[k+1] <= nxt;
			end
		end
	end

	// sign fix and range check on the quotient
	logic [W:0] qs;
	logic       q_ovf;
	assign qs    = stg_s[W].q_neg ? (W+1)'(-{1'b0, stg_s[W].quo}) : {1'b0, stg_s[W].quo};
	assign q_ovf = !((&qs[W:31]) || !(|qs[W:31]));

	always_comb begin
		o_data.a_less      = stg_s[W].lt;
		o_data.a_equal     = stg_s[W].eq;
		o_data.a_greater   = stg_s[W].gt;
		o_data.div_by_zero = 1'b0;
		o_data.overflow    = 1'b0;
		o_data.result      = stg_s[W].res;
		if (stg_s[W].func == fpa_pkg::OP_DIV) begin
			if (stg_s[W].b_zero) begin
				o_data.div_by_zero = 1'b1;
				o_data.result      = '0;
			end else begin
				o_data.overflow = q_ovf;
				o_data.result   = qs[31:0];
			end
		end
	end

	assign o_wr = stg_s[W].valid && !o_full;

endmodule

[src/fixed_point_alu_q24_8.sv]
// Signed Q24.8 fixed-point ALU, top level.
// Depends on fpa_pkg, fpa_front, fpa_fifo, fpa_back.
//
// Input channel: req carries func, operand_a, operand_b; a beat is taken at a
// clock edge with push high and full low. Result channel: rsp holds the oldest
// result while empty is low; it is taken at an edge with pop high.
// Operations: add, sub, mul, div, min, max, from_int, to_int, inc, dec; every
// beat also reports a<b, a==b and a>b. Divide by zero gives 0 with
// div_by_zero; an out-of-range quotient sets overflow.
// Throughput: one beat per cycle while full is low, all operations alike.
// A beat passes the front register, the middle queue, entry 0, then 40 stages
// of restoring divide at FRAC_BITS = 8 (one quotient bit each) and the result
// queue; every operation walks the same in-order pipe.
// A 4-deep queue decouples front from back; a 2-deep queue holds results.
// Reset clears all queues and the pipe; no state survives between beats.
// When pop is held low the result queue fills, the back pipe freezes, the
// middle queue fills, then full rises; no beat is lost.
module fixed_point_alu_q24_8 #(
	parameter int FRAC_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  fpa_pkg::in_t  req,
	output logic          empty,
	input  logic          pop,
	output fpa_pkg::out_t rsp
);
	fpa_pkg::cls_t fr_data, mid_data;
	fpa_pkg::out_t bk_data;
	logic          fr_wr, mid_full, mid_empty, mid_rd;
	logic          o_full, o_wr;

	fpa_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .req(req), .full(full),
		.q_full(mid_full), .q_wr(fr_wr), .q_data(fr_data)
	);

	fpa_fifo #(.WIDTH($bits(fpa_pkg::cls_t)), .DEPTH(fpa_pkg::MID_DEPTH)) u_mid (
		.clk(clk), .arst_n(arst_n), .wr(fr_wr), .wr_data(fr_data), .rd(mid_rd),
		.rd_data(mid_data), .full(mid_full), .empty(mid_empty)
	);

	fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(mid_empty), .q_data(mid_data),
		.q_rd(mid_rd), .o_full(o_full), .o_wr(o_wr), .o_data(bk_data)
	);

	fpa_fifo #(.WIDTH($bits(fpa_pkg::out_t)), .DEPTH(fpa_pkg::OUT_DEPTH)) u_out (
		.clk(clk), .arst_n(arst_n), .wr(o_wr), .wr_data(bk_data),
		.rd(pop && !empty), .rd_data(rsp), .full(o_full), .empty(empty)
	);

endmodule
